>>> src/ccns_pkg.sv
`timescale 1ns / 1ps

package ccns_pkg;

    // Widths of the converter's words.
    localparam int COUNT_W  = 64;
    localparam int RATE_W   = 34;
    localparam int OFFSET_W = 63;
    localparam int NS_W     = 30;

    // Default scale factor: nanoseconds in one second.
    localparam int unsigned NS_PER_SECOND_DEF = 1000000000;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_RATE   = 1'b0,
        CFG_OFFSET = 1'b1
    } t_cfg_idx;

endpackage

>>> src/ccns_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per register stage.
module ccns_div #(
    parameter int N  = 64,
    parameter int DW = 34,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [N-1:0]  i_dividend,
    input  logic [DW-1:0] i_divisor,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [N-1:0]  o_quot,
    output logic [DW-1:0] o_rem,
    output logic [SW-1:0] o_side
);

    logic          r_valid [N];
    logic [N-1:0]  r_acc   [N];
    logic [DW-1:0] r_rem   [N];
    logic [SW-1:0] r_side  [N];

    genvar k;
    generate
        for (k = 0; k < N; k++) begin : g_stage
            logic          valid_in;
            logic [N-1:0]  acc_in;
            logic [DW-1:0] rem_in;
            logic [SW-1:0] side_in;
            logic [DW:0]   trial;
            logic [DW:0]   diff;
            logic          ge;

            if (k == 0) begin : g_first
                assign valid_in = i_valid;
                assign acc_in   = i_dividend;
                assign rem_in   = '0;
                assign side_in  = i_side;
            end else begin : g_next
                assign valid_in = r_valid[k-1];
                assign acc_in   = r_acc[k-1];
                assign rem_in   = r_rem[k-1];
                assign side_in  = r_side[k-1];
            end

            // Bring down the next dividend bit and try the subtraction.
            assign trial = {rem_in, acc_in[N-1]};
            assign ge    = trial >= {1'b0, i_divisor};
            assign diff  = trial - {1'b0, i_divisor};

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[k] <= 1'b0;
                end else begin
                    r_valid[k] <= valid_in;
                end
            end

            // The quotient bits shift in as the dividend bits shift out.
            always_ff @(posedge i_clk) begin
                r_acc[k]  <= {acc_in[N-2:0], ge};
                r_rem[k]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
                r_side[k] <= side_in;
            end
        end
    endgenerate

    assign o_valid = r_valid[N-1];
    assign o_quot  = r_acc[N-1];
    assign o_rem   = r_rem[N-1];
    assign o_side  = r_side[N-1];

    // The remainder always ends below the divisor.
    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rem < i_divisor))
        else $error("divider remainder not below divisor");

    // A word leaves only after passing through every register stage of the divider.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_valid, N))
        else $error("divider output without matching input");

endmodule

>>> src/ccns_mul.sv
`timescale 1ns / 1ps

// Scales whole seconds and remainder cycles to ns; adds offset if i_op is set.
module ccns_mul #(
    parameter int unsigned NS_PER_SECOND = ccns_pkg::NS_PER_SECOND_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [ccns_pkg::COUNT_W-1:0]    i_secs,
    input  logic [ccns_pkg::RATE_W-1:0]     i_rem,
    input  logic                            i_op,
    input  logic [ccns_pkg::OFFSET_W-1:0]   i_offset,
    output logic                            o_valid,
    output logic [ccns_pkg::COUNT_W-1:0]    o_base,
    output logic [ccns_pkg::COUNT_W-1:0]    o_rem_ns
);
    import ccns_pkg::*;

    localparam int HALF_W = COUNT_W / 2;

    logic [NS_W-1:0] c_ns;
    assign c_ns = NS_W'(NS_PER_SECOND);

    logic [2:0]                 r_valid;
    logic [HALF_W+NS_W-1:0]     r_lo;
    logic [HALF_W-1:0]          r_hi;
    logic [COUNT_W-1:0]         r_rem_ns1;
    logic                       r_op1;
    logic [COUNT_W-1:0]         r_secs_ns;
    logic [COUNT_W-1:0]         r_rem_ns2;
    logic                       r_op2;
    logic [COUNT_W-1:0]         r_base;
    logic [COUNT_W-1:0]         r_rem_ns3;

    logic [HALF_W+NS_W-1:0]     n_hi_full;
    logic [COUNT_W-1:0]         n_rem_ns;
    logic [COUNT_W-1:0]         n_secs_ns;
    logic [COUNT_W-1:0]         n_base;

    // Stage one: two half-width products of the seconds and the remainder product.
    assign n_hi_full = i_secs[COUNT_W-1:HALF_W] * c_ns;
    assign n_rem_ns  = COUNT_W'(i_rem) * COUNT_W'(c_ns);
    // Stage two: recombine the seconds product modulo 2^64.
    assign n_secs_ns = COUNT_W'(r_lo) + {r_hi, {HALF_W{1'b0}}};
    // Stage three: add the wall-clock offset in absolute mode.
    assign n_base    = r_secs_ns + (r_op2 ? {1'b0, i_offset} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo      <= i_secs[HALF_W-1:0] * c_ns;
        r_hi      <= n_hi_full[HALF_W-1:0];
        r_rem_ns1 <= n_rem_ns;
        r_op1     <= i_op;
        r_secs_ns <= n_secs_ns;
        r_rem_ns2 <= r_rem_ns1;
        r_op2     <= r_op1;
        r_base    <= n_base;
        r_rem_ns3 <= r_rem_ns2;
    end

    assign o_valid  = r_valid[2];
    assign o_base   = r_base;
    assign o_rem_ns = r_rem_ns3;

    // A scaled word leaves only after it has passed through every stage.
    a_lineage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_valid, 3))
        else $error("scaler output without matching input");

endmodule

>>> src/cycle_count_to_nanoseconds_top.sv
`timescale 1ns / 1ps

// Cycle count to nanoseconds converter.
// A word is taken at a clock edge where i_start is high; o_busy stays low,
// so a new count may be presented in every cycle. i_op selects a plain
// duration (0) or a duration plus the configured wall-clock offset (1).
// The converted value appears on o_time_ns for one cycle with o_done high,
// after the word has passed 64 stages of the seconds divider,
// three stages of scaling and offset addition, 64 stages of the remainder
// divider and one final adder stage. Throughput is one word per cycle.
// The receiver cannot stall; results are delivered in order.
// Registers are written through i_cfg_we, i_cfg_idx and i_cfg_wdata:
// index 0 is the clock rate in hertz (34 bits, zero acts as one) and
// index 1 the offset in nanoseconds (63 bits). Write them only when the
// pipeline is empty. Reset sets the rate to one and the offset to zero and
// empties the pipeline, dropping any words in flight.
module cycle_count_to_nanoseconds_top #(
    parameter int unsigned NS_PER_SECOND = ccns_pkg::NS_PER_SECOND_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic [ccns_pkg::COUNT_W-1:0]    i_cycle_count,
    input  logic                            i_op,
    output logic                            o_done,
    output logic [ccns_pkg::COUNT_W-1:0]    o_time_ns,
    input  logic                            i_cfg_we,
    input  logic [0:0]                      i_cfg_idx,
    input  logic [ccns_pkg::OFFSET_W-1:0]   i_cfg_wdata
);
    import ccns_pkg::*;

    logic [RATE_W-1:0]   r_rate;
    logic [OFFSET_W-1:0] r_offset;
    logic [RATE_W-1:0]   divisor;

    logic                d1_valid;
    logic [COUNT_W-1:0]  d1_quot;
    logic [RATE_W-1:0]   d1_rem;
    logic                d1_op;

    logic                m_valid;
    logic [COUNT_W-1:0]  m_base;
    logic [COUNT_W-1:0]  m_rem_ns;

    logic                d2_valid;
    logic [COUNT_W-1:0]  d2_quot;
    logic [COUNT_W-1:0]  d2_base;

    logic                r_done;
    logic [COUNT_W-1:0]  r_time;

    assign o_busy = 1'b0;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate   <= RATE_W'(1);
            r_offset <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_RATE:   r_rate   <= i_cfg_wdata[RATE_W-1:0];
                CFG_OFFSET: r_offset <= i_cfg_wdata;
                default:    ;
            endcase
        end
    end

    // A zero rate divides as one.
    assign divisor = (r_rate == '0) ? RATE_W'(1) : r_rate;

    // Whole seconds and leftover cycles.
    ccns_div #(
        .N  (COUNT_W),
        .DW (RATE_W),
        .SW (1)
    ) u_div_secs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_start),
        .i_dividend (i_cycle_count),
        .i_divisor  (divisor),
        .i_side     (i_op),
        .o_valid    (d1_valid),
        .o_quot     (d1_quot),
        .o_rem      (d1_rem),
        .o_side     (d1_op)
    );

    ccns_mul #(
        .NS_PER_SECOND (NS_PER_SECOND)
    ) u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (d1_valid),
        .i_secs   (d1_quot),
        .i_rem    (d1_rem),
        .i_op     (d1_op),
        .i_offset (r_offset),
        .o_valid  (m_valid),
        .o_base   (m_base),
        .o_rem_ns (m_rem_ns)
    );

    // Fractional second in nanoseconds; the base rides alongside.
    ccns_div #(
        .N  (COUNT_W),
        .DW (RATE_W),
        .SW (COUNT_W)
    ) u_div_frac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (m_valid),
        .i_dividend (m_rem_ns),
        .i_divisor  (divisor),
        .i_side     (m_base),
        .o_valid    (d2_valid),
        .o_quot     (d2_quot),
        .o_rem      (),
        .o_side     (d2_base)
    );

    // Final sum, wrapping modulo 2^64.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= d2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_time <= d2_base + d2_quot;
    end

    assign o_done    = r_done;
    assign o_time_ns = r_time;

endmodule

>>> tb/sv/tb_cycle_count_to_nanoseconds_top.sv
`timescale 1ns / 1ps

module tb_cycle_count_to_nanoseconds_top;

    import ccns_pkg::*;

    localparam int          LATENCY      = 132;
    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          PHASES       = 8;
    localparam int          WORDS_PHASE  = 250;
    localparam logic [63:0] NS_SEC       = 64'(NS_PER_SECOND_DEF);
    localparam logic [62:0] OFFSET_MAX   = {63{1'b1}};
    localparam logic [33:0] RATE_MAX     = {34{1'b1}};

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_start;
    logic                  o_busy;
    logic [COUNT_W-1:0]    i_cycle_count;
    logic                  i_op;
    logic                  o_done;
    logic [COUNT_W-1:0]    o_time_ns;
    logic                  i_cfg_we;
    logic [0:0]            i_cfg_idx;
    logic [OFFSET_W-1:0]   i_cfg_wdata;

    // Mirror of the configuration registers as the converter should hold them.
    logic [RATE_W-1:0]     rate_hz;
    logic [OFFSET_W-1:0]   offset_ns;

    // Converted times still awaited from the pipeline, oldest first.
    logic [63:0]           pending_ns[$];

    // A directed row may supply its own hand-worked result.
    logic                  typed_ns_en;
    logic [63:0]           typed_ns;

    int                    errors;
    int                    cycles;
    bit                    no_idle;

    typedef struct {
        bit            is_cfg;
        t_cfg_idx      idx;
        logic [62:0]   wdata;
        logic [63:0]   count;
        logic          op;
        bit            typed;
        logic [63:0]   result;
    } t_row;

    cycle_count_to_nanoseconds_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_cycle_count (i_cycle_count),
        .i_op          (i_op),
        .o_done        (o_done),
        .o_time_ns     (o_time_ns),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Whole seconds scaled up, plus the scaled remainder, plus the offset if asked.
    function automatic logic [63:0] converted_ns(logic [63:0] count, logic op);
        logic [63:0] divisor;
        logic [63:0] secs;
        logic [63:0] rem;
        logic [63:0] total;
        divisor = (rate_hz == '0) ? 64'd1 : {30'd0, rate_hz};
        secs    = count / divisor;
        rem     = count - secs * divisor;
        total   = secs * NS_SEC + (rem * NS_SEC) / divisor;
        if (op) begin
            total = total + {1'b0, offset_ns};
        end
        return total;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    // Record each accepted word and check each result word against the oldest.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                pending_ns.push_back(typed_ns_en ? typed_ns
                                                 : converted_ns(i_cycle_count, i_op));
            end
            if (o_done) begin
                if (pending_ns.size() == 0) begin
                    report("unexpected word", o_time_ns, 64'd0);
                end else if (o_time_ns !== pending_ns[0]) begin
                    report("time_ns", o_time_ns, pending_ns.pop_front());
                end else begin
                    void'(pending_ns.pop_front());
                end
            end
        end
    end

    // Watchdog on the overall run length.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic drain();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (pending_ns.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Registers are only written once the pipeline has emptied.
    task automatic write_register(t_cfg_idx idx, logic [62:0] wdata);
        drain();
        @(negedge i_clk);
        if (idx == CFG_RATE) begin
            rate_hz = wdata[RATE_W-1:0];
        end else begin
            offset_ns = wdata;
        end
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= wdata;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic send_word(logic [63:0] count, logic op, bit typed, logic [63:0] result);
        while (!no_idle && $urandom_range(0, 99) < 14) begin
            @(negedge i_clk);
            i_start <= 1'b0;
        end
        @(negedge i_clk);
        i_start       <= 1'b1;
        i_cycle_count <= count;
        i_op          <= op;
        typed_ns_en   <= typed;
        typed_ns      <= result;
        do begin
            @(posedge i_clk);
        end while (o_busy);
    endtask

    function automatic logic [63:0] random_count();
        logic [63:0] divisor;
        divisor = (rate_hz == '0) ? 64'd1 : {30'd0, rate_hz};
        case ($urandom_range(0, 3))
            0:       return {$urandom(), $urandom()};
            1:       return 64'($urandom_range(0, 1000));
            2:       return divisor * 64'($urandom()) + 64'($urandom_range(0, 2)) - 64'd1;
            default: return ~64'($urandom_range(0, 1000));
        endcase
    endfunction

    function automatic logic [62:0] random_rate();
        case ($urandom_range(0, 5))
            0:       return 63'd1;
            1:       return 63'd0;
            2:       return {29'd0, RATE_MAX};
            3:       return 63'd1000000000;
            4:       return 63'($urandom_range(2, 100));
            default: return 63'({$urandom(), $urandom()});
        endcase
    endfunction

    function automatic logic [62:0] random_offset();
        case ($urandom_range(0, 3))
            0:       return 63'd0;
            1:       return OFFSET_MAX;
            default: return 63'({$urandom(), $urandom()});
        endcase
    endfunction

    t_row directed[] = '{
        // Reset values: rate one, offset zero.
        '{0, CFG_RATE, 63'd0, 64'd0, 1'b0, 1, 64'd0},
        '{0, CFG_RATE, 63'd0, 64'd1, 1'b1, 1, 64'd1000000000},
        '{0, CFG_RATE, 63'd0, '1,    1'b0, 1, 64'd18446744072709551616},
        // A zero rate behaves as a rate of one.
        '{1, CFG_RATE, 63'd0, 64'd0, 1'b0, 0, 64'd0},
        '{0, CFG_RATE, 63'd0, 64'd3, 1'b0, 1, 64'd3000000000},
        '{0, CFG_RATE, 63'd0, '1,    1'b1, 1, 64'd18446744072709551616},
        // Largest offset, including a sum that wraps.
        '{1, CFG_OFFSET, OFFSET_MAX, 64'd0, 1'b0, 0, 64'd0},
        '{0, CFG_RATE, 63'd0, 64'd0, 1'b1, 1, 64'd9223372036854775807},
        '{0, CFG_RATE, 63'd0, '1,    1'b1, 0, 64'd0},
        '{0, CFG_RATE, 63'd0, 64'h7fff_ffff_ffff_ffff, 1'b1, 0, 64'd0},
        // Bits of the rate above its width are dropped.
        '{1, CFG_RATE, OFFSET_MAX, 64'd0, 1'b0, 0, 64'd0},
        '{0, CFG_RATE, 63'd0, 64'd17179869183, 1'b0, 1, 64'd1000000000},
        '{0, CFG_RATE, 63'd0, '1,    1'b0, 0, 64'd0},
        '{0, CFG_RATE, 63'd0, 64'd17179869182, 1'b1, 0, 64'd0},
        // A rate of one gigahertz maps cycles to nanoseconds.
        '{1, CFG_RATE, 63'd1000000000, 64'd0, 1'b0, 0, 64'd0},
        '{0, CFG_RATE, 63'd0, 64'd123456789, 1'b0, 1, 64'd123456789},
        '{0, CFG_RATE, 63'd0, '1,    1'b1, 0, 64'd0},
        // Small rate with remainders.
        '{1, CFG_RATE, 63'd3, 64'd0, 1'b0, 0, 64'd0},
        '{1, CFG_OFFSET, 63'd5, 64'd0, 1'b0, 0, 64'd0},
        '{0, CFG_RATE, 63'd0, 64'd1, 1'b0, 0, 64'd0},
        '{0, CFG_RATE, 63'd0, 64'd2, 1'b1, 0, 64'd0},
        '{0, CFG_RATE, 63'd0, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 0, 64'd0},
        '{0, CFG_RATE, 63'd0, 64'h5555_5555_5555_5555, 1'b1, 0, 64'd0}
    };

    initial begin
        errors        = 0;
        cycles        = 0;
        no_idle       = 0;
        rate_hz       = 34'd1;
        offset_ns     = '0;
        typed_ns_en   = 1'b0;
        typed_ns      = '0;
        i_rst_n       = 1'b0;
        i_start       = 1'b0;
        i_cycle_count = '0;
        i_op          = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_RATE;
        i_cfg_wdata   = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table.
        foreach (directed[i]) begin
            if (directed[i].is_cfg) begin
                write_register(directed[i].idx, directed[i].wdata);
            end else begin
                send_word(directed[i].count, directed[i].op,
                          directed[i].typed, directed[i].result);
            end
        end

        // Random phases, each under fresh register values.
        for (int p = 0; p < PHASES; p++) begin
            write_register(CFG_RATE, random_rate());
            write_register(CFG_OFFSET, random_offset());
            no_idle = (p == 2);
            for (int n = 0; n < WORDS_PHASE; n++) begin
                send_word(random_count(), 1'($urandom()), 1'b0, 64'd0);
            end
        end

        drain();
        repeat (LATENCY + 20) @(posedge i_clk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
